>>> sv/wildcard_filename_matcher_top_defines.svh
// assertion macros for the wildcard file-name matcher
`ifndef WILDCARD_FILENAME_MATCHER_TOP_DEFINES_SVH
`define WILDCARD_FILENAME_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define WFM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define WFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/wfm_pkg.sv
// types, constants and helpers shared by the wildcard matcher files
`default_nettype none

package wfm_pkg;

    localparam int LP_MAX_TEMPLATE = 64;
    localparam int LP_IDX_W        = $clog2(LP_MAX_TEMPLATE);
    localparam int LP_LEN_W        = $clog2(LP_MAX_TEMPLATE + 1);

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PERIOD = 8'h2E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_CASE   = 8'h20;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NAME = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_NAME   = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_PERIOD = 2'd1;
    localparam logic [1:0] ST_TOO_LONG  = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_CHECK,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       kind;
        logic       matched;
        logic [1:0] status;
    } t_result;

    typedef struct packed {
        logic                we;
        logic [LP_IDX_W-1:0] waddr;
        logic [7:0]          wdata;
        logic [LP_IDX_W-1:0] raddr;
    } t_ram_req;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] res;
        res = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            res = c - CH_CASE;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> sv/wfm_if.sv
// valid/ready channels for template and name bytes in, result words out
`default_nettype none

interface wfm_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output op, output symbol, output last, input ready);
    modport sink   (input valid, input op, input symbol, input last, output ready);
endinterface

interface wfm_out_if;
    logic       valid;
    logic       ready;
    logic       verdict_kind;
    logic       matched;
    logic [1:0] template_status;

    modport source (output valid, output verdict_kind, output matched,
                    output template_status, input ready);
    modport sink   (input valid, input verdict_kind, input matched,
                    input template_status, output ready);
endinterface

`default_nettype wire

>>> sv/wildcard_filename_matcher_top.sv
// top level of the wildcard file-name matcher
// a byte is taken in idle and handled in exec; a last byte's result goes to the output register
// for a name's last byte the check state may first scan trailing star-period pairs
// a new byte is taken only in idle, once the last is done; a stalled result waits in emit
// reset: synchronous active low, clears control state; template ram is not cleared
// after reset the template is empty and every name matches
`default_nettype none

module wildcard_filename_matcher_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wfm_in_if.sink    i_in,
    wfm_out_if.source o_out
);
    import wfm_pkg::*;

    // sequencer to ram, and sequencer to output register
    t_ram_req   w_ram_req;
    logic [7:0] w_ram_rdata;
    logic       w_in_ready;
    logic       w_res_valid;
    logic       w_res_ready;
    t_result    w_res;

    // output register holding one result word
    logic    r_out_valid;
    t_result r_out;

    wfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (w_in_ready),
        .i_op        (i_in.op),
        .i_symbol    (i_in.symbol),
        .i_last      (i_in.last),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready),
        .o_ram_req   (w_ram_req),
        .i_ram_rdata (w_ram_rdata)
    );

    wfm_tmpl_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

    assign i_in.ready = w_in_ready;

    // a new word may enter when the register is empty or being drained
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload needs no reset, qualified by r_out_valid
    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.verdict_kind    = r_out.kind;
    assign o_out.matched         = r_out.matched;
    assign o_out.template_status = r_out.status;

endmodule

`default_nettype wire

>>> sv/wfm_tmpl_ram.sv
// template store: one write port, one registered read port
`default_nettype none

module wfm_tmpl_ram (
    input  wire logic              i_clk,
    input  wire wfm_pkg::t_ram_req i_req,
    output logic [7:0]             o_rdata
);
    import wfm_pkg::*;

    logic [7:0] r_mem [LP_MAX_TEMPLATE];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

`default_nettype wire

>>> sv/wfm_ctrl.sv
// sequencer: template load, name byte matching and end-of-name pair scan
`default_nettype none

module wfm_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_op,
    input  wire logic [7:0]        i_symbol,
    input  wire logic              i_last,
    output logic                   o_res_valid,
    output wfm_pkg::t_result       o_res,
    input  wire logic              i_res_ready,
    output wfm_pkg::t_ram_req      o_ram_req,
    input  wire logic [7:0]        i_ram_rdata
);
    import wfm_pkg::*;

    localparam logic [LP_LEN_W-1:0] LP_LEN_MAX = LP_LEN_W'(LP_MAX_TEMPLATE);

    t_state              r_state, n_state;
    logic                r_op, n_op;
    logic [7:0]          r_sym, n_sym;
    logic                r_last, n_last;
    logic [LP_LEN_W-1:0] r_len, n_len;
    logic [1:0]          r_err, n_err;
    logic                r_star, n_star;
    logic                r_fresh, n_fresh;
    logic [LP_LEN_W-1:0] r_pos, n_pos;
    logic                r_skip, n_skip;
    logic                r_failed, n_failed;
    logic                r_accepted, n_accepted;
    t_result             r_pend, n_pend;

    logic [LP_LEN_W-1:0] w_len0;
    logic [1:0]          w_err0;
    logic                w_star0;
    logic [LP_LEN_W:0]   w_pos_p1;
    logic [LP_LEN_W:0]   w_len_x;
    logic                w_hit;
    logic                w_hit_name;
    t_result             w_res;

    assign w_len0   = r_fresh ? '0 : r_len;
    assign w_err0   = r_fresh ? ST_OK : r_err;
    assign w_star0  = r_fresh ? 1'b0 : r_star;
    assign w_pos_p1 = {1'b0, r_pos} + 1'b1;
    assign w_len_x  = {1'b0, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_len      <= '0;
            r_err      <= ST_OK;
            r_star     <= 1'b0;
            r_fresh    <= 1'b1;
            r_pos      <= '0;
            r_skip     <= 1'b0;
            r_failed   <= 1'b0;
            r_accepted <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_len      <= n_len;
            r_err      <= n_err;
            r_star     <= n_star;
            r_fresh    <= n_fresh;
            r_pos      <= n_pos;
            r_skip     <= n_skip;
            r_failed   <= n_failed;
            r_accepted <= n_accepted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_sym  <= n_sym;
        r_last <= n_last;
        r_pend <= n_pend;
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_sym      = r_sym;
        n_last     = r_last;
        n_len      = r_len;
        n_err      = r_err;
        n_star     = r_star;
        n_fresh    = r_fresh;
        n_pos      = r_pos;
        n_skip     = r_skip;
        n_failed   = r_failed;
        n_accepted = r_accepted;
        n_pend     = r_pend;
        w_hit      = 1'b0;
        w_hit_name = 1'b0;
        w_res      = '0;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_res       = r_pend;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = w_len0[LP_IDX_W-1:0];
        o_ram_req.wdata = upcase(r_sym);

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_op    = i_op;
                    n_sym   = i_symbol;
                    n_last  = i_last;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (r_op == OP_LOAD) begin
                    n_len   = w_len0;
                    n_err   = w_err0;
                    n_star  = w_star0;
                    n_fresh = 1'b0;
                    if (w_err0 == ST_OK) begin
                        if (w_star0 && r_sym != CH_PERIOD) begin
                            n_err = ST_NO_PERIOD;
                        end else begin
                            n_star = (r_sym == CH_STAR);
                            if (w_len0 >= LP_LEN_MAX) begin
                                n_err = ST_TOO_LONG;
                            end else begin
                                o_ram_req.we = 1'b1;
                                n_len = w_len0 + LP_LEN_W'(1);
                            end
                        end
                    end
                    if (r_last) begin
                        n_fresh = 1'b1;
                        w_hit   = 1'b1;
                        w_res   = '{kind: KIND_STATUS, matched: 1'b0, status: n_err};
                    end
                end else begin
                    // ram data is the template byte at r_pos
                    if (!(r_failed || r_accepted)) begin
                        if (r_skip) begin
                            if (r_sym == CH_PERIOD) begin
                                n_skip = 1'b0;
                            end
                        end else if (r_pos >= r_len) begin
                            n_failed = 1'b1;
                        end else if (i_ram_rdata == CH_STAR) begin
                            if (w_pos_p1 == w_len_x) begin
                                n_accepted = 1'b1;
                            end else begin
                                n_pos  = r_pos + LP_LEN_W'(2);
                                n_skip = (r_sym != CH_PERIOD);
                            end
                        end else if (i_ram_rdata != CH_QUEST
                                     && upcase(r_sym) != i_ram_rdata) begin
                            n_failed = 1'b1;
                        end else begin
                            n_pos = r_pos + LP_LEN_W'(1);
                        end
                    end
                    if (r_last) begin
                        w_res = '{kind: KIND_NAME, matched: 1'b0, status: r_err};
                        if (r_err != ST_OK) begin
                            w_hit = 1'b1;
                        end else if (r_len == '0) begin
                            w_hit = 1'b1;
                            w_res.matched = 1'b1;
                        end else if (n_failed) begin
                            w_hit = 1'b1;
                        end else if (n_accepted) begin
                            w_hit = 1'b1;
                            w_res.matched = 1'b1;
                        end else begin
                            n_state = S_CHECK;
                        end
                        w_hit_name = w_hit;
                    end
                end
            end
            S_CHECK: begin
                // remaining template must be star-period pairs or a final star
                w_res = '{kind: KIND_NAME, matched: 1'b0, status: r_err};
                if (r_pos >= r_len) begin
                    w_hit = 1'b1;
                    w_res.matched = 1'b1;
                end else if (i_ram_rdata != CH_STAR) begin
                    w_hit = 1'b1;
                end else if (w_pos_p1 == w_len_x) begin
                    w_hit = 1'b1;
                    w_res.matched = 1'b1;
                end else begin
                    n_pos = r_pos + LP_LEN_W'(2);
                end
                w_hit_name = w_hit;
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                o_res       = r_pend;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_hit) begin
            if (w_hit_name) begin
                n_pos      = '0;
                n_skip     = 1'b0;
                n_failed   = 1'b0;
                n_accepted = 1'b0;
            end
            if (i_res_ready) begin
                o_res_valid = 1'b1;
                o_res       = w_res;
                n_state     = S_IDLE;
            end else begin
                n_pend  = w_res;
                n_state = S_EMIT;
            end
        end

        // read address follows the next match position so data lines up with r_pos
        o_ram_req.raddr = n_pos[LP_IDX_W-1:0];
    end

endmodule

`default_nettype wire

>>> sv/wfm_chk.sv
// port-level checks on the result channel, bound to the top level
`default_nettype none
`include "wildcard_filename_matcher_top_defines.svh"

module wfm_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic       i_out_kind,
    input wire logic       i_out_matched,
    input wire logic [1:0] i_out_status
);
    import wfm_pkg::*;

    `WFM_ASSERT_NEXT(a_valid_hold, i_out_valid && !i_out_ready, i_out_valid, "word dropped while stalled")
    `WFM_ASSERT_NEXT(a_word_hold, i_out_valid && !i_out_ready, $stable(i_out_kind) && $stable(i_out_matched) && $stable(i_out_status), "word changed while stalled")
    `WFM_ASSERT_NOW(a_status_unmatched, i_out_valid && i_out_kind == KIND_STATUS, !i_out_matched, "template status word flagged as match")
    `WFM_ASSERT_NOW(a_bad_tmpl_no_match, i_out_valid && i_out_kind == KIND_NAME && i_out_status != ST_OK, !i_out_matched, "match reported against a bad template")
    `WFM_ASSERT_NOW(a_status_code, i_out_valid, i_out_status == ST_OK || i_out_status == ST_NO_PERIOD || i_out_status == ST_TOO_LONG, "unknown template status code")

endmodule

bind wildcard_filename_matcher_top wfm_chk u_wfm_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_kind    (o_out.verdict_kind),
    .i_out_matched (o_out.matched),
    .i_out_status  (o_out.template_status)
);

`default_nettype wire
